// ===== design/ist_pkg.sv =====
// ist_pkg: shared codes, widths and control structs of the interval set table
// used by ist_ctrl, ist_dp and interval_set_table
// no dependencies
package ist_pkg;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int OP_W      = 2;
    localparam int FIELD_T_W = 32;
    localparam int STATUS_W  = 2;
    localparam int FRAC_W    = 17;
    localparam int COUNT_W   = 7;
    localparam int FRAC_BITS = 16;
    localparam int DIV_CNT_W = 4;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic load;
        logic rd;
        logic proc;
        logic wpend;
        logic fin;
        logic div;
        logic out;
    } ist_cmd_t;

    typedef struct packed {
        logic req_ok;
        logic is_query;
        logic more;
        logic pend_req;
        logic div_last;
        logic out_free;
    } ist_stat_t;

endpackage

// ===== design/ist_ctrl.sv =====
// ist_ctrl: sequencer of the interval set table
// walks the stored entries, the division steps and the result handoff
// depends on ist_pkg
module ist_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ist_pkg::ist_stat_t stat,
    output ist_pkg::ist_cmd_t  cmd
);
    import ist_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PROC = 3'd2;
    localparam logic [2:0] S_PEND = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (!stat.req_ok) begin
                    state_next = S_OUT;
                end else if (stat.more) begin
                    cmd.rd     = 1'b1;
                    state_next = S_PROC;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_PROC: begin
                cmd.proc   = 1'b1;
                state_next = stat.pend_req ? S_PEND : S_RD;
            end
            S_PEND: begin
                cmd.wpend  = 1'b1;
                state_next = S_RD;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = stat.is_query ? S_DIV : S_OUT;
            end
            S_DIV: begin
                cmd.div = 1'b1;
                if (stat.div_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

endmodule

// ===== design/ist_dp.sv =====
// ist_dp: datapath of the interval set table
// ping-pong interval memory, merge/trim/split rewrite, coverage sum, fraction divider
// depends on ist_pkg
module ist_dp #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ist_pkg::ist_cmd_t               cmd,
    output ist_pkg::ist_stat_t              stat,
    input  logic [ist_pkg::OP_W-1:0]        operation,
    input  logic [ist_pkg::FIELD_T_W-1:0]   range_start,
    input  logic [ist_pkg::FIELD_T_W-1:0]   range_end,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ist_pkg::STATUS_W-1:0]    status,
    output logic [ist_pkg::FRAC_W-1:0]      covered_fraction,
    output logic [ist_pkg::COUNT_W-1:0]     entry_count
);
    import ist_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int EW = 2 * TW;
    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 2);
    localparam int XW = TW + FIELD_T_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_MERGE  = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    logic [EW-1:0] mem [2**(AW+1)];

    logic [OP_W-1:0]      op_reg;
    logic [TW-1:0]        s_reg, e_reg;
    logic                 bank_reg;
    logic [CW-1:0]        n_reg, i_reg, w_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [TW-1:0]        acc_s_reg, acc_s_next, acc_e_reg, acc_e_next;
    logic [TW-1:0]        pend_a_reg, pend_z_reg;
    logic [TW-1:0]        cov_reg, cov_next;
    logic [TW-1:0]        rem_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic                 full_frac_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [EW-1:0]        rd_data_reg;
    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [XW-1:0] start_ext, end_ext;
    logic [TW-1:0] s_in, e_in, ent_a, ent_z, len, lo, hi;
    logic [TW-1:0] wr_a, wr_z;
    logic          wr_req, pend_set, req_ok, commit_ok, over_full;
    logic [TW:0]   rem_sh;

    assign start_ext = {{TW{1'b0}}, range_start};
    assign end_ext   = {{TW{1'b0}}, range_end};
    assign s_in      = start_ext[TW-1:0];
    assign e_in      = end_ext[TW-1:0];

    assign ent_a  = rd_data_reg[TW-1:0];
    assign ent_z  = rd_data_reg[EW-1:TW];
    assign len    = e_reg - s_reg;
    assign rem_sh = {rem_reg, 1'b0};

    assign req_ok = (op_reg == OP_MARK || op_reg == OP_CLEAR || op_reg == OP_QUERY)
                    && (s_reg < e_reg);
    assign over_full = (w_reg > MAX_CNT);
    assign commit_ok = req_ok && (op_reg != OP_QUERY) && !over_full;

    always_comb begin
        wr_req     = 1'b0;
        wr_a       = ent_a;
        wr_z       = ent_z;
        pend_set   = 1'b0;
        phase_next = phase_reg;
        acc_s_next = acc_s_reg;
        acc_e_next = acc_e_reg;
        cov_next   = cov_reg;
        lo         = (ent_a > s_reg) ? ent_a : s_reg;
        hi         = (ent_z < e_reg) ? ent_z : e_reg;
        if (cmd.proc) begin
            case (op_reg)
                OP_MARK: begin
                    case (phase_reg)
                        PH_BEFORE: begin
                            if (ent_z < s_reg) begin
                                wr_req = 1'b1;
                            end else if (ent_a <= e_reg) begin
                                acc_s_next = (ent_a < s_reg) ? ent_a : s_reg;
                                acc_e_next = (ent_z > e_reg) ? ent_z : e_reg;
                                phase_next = PH_MERGE;
                            end else begin
                                wr_req     = 1'b1;
                                wr_a       = s_reg;
                                wr_z       = e_reg;
                                pend_set   = 1'b1;
                                phase_next = PH_AFTER;
                            end
                        end
                        PH_MERGE: begin
                            if (ent_a <= e_reg) begin
                                if (ent_z > acc_e_reg) begin
                                    acc_e_next = ent_z;
                                end
                            end else begin
                                wr_req     = 1'b1;
                                wr_a       = acc_s_reg;
                                wr_z       = acc_e_reg;
                                pend_set   = 1'b1;
                                phase_next = PH_AFTER;
                            end
                        end
                        default: wr_req = 1'b1;
                    endcase
                end
                OP_CLEAR: begin
                    if (s_reg <= ent_a && ent_z <= e_reg) begin
                        wr_req = 1'b0;
                    end else if (ent_a < s_reg && e_reg < ent_z) begin
                        wr_req   = 1'b1;
                        wr_z     = s_reg;
                        pend_set = 1'b1;
                    end else begin
                        wr_req = 1'b1;
                        if (ent_a < e_reg && e_reg < ent_z) begin
                            wr_a = e_reg;
                        end
                        if (ent_a < s_reg && s_reg < ent_z) begin
                            wr_z = s_reg;
                        end
                    end
                end
                default: begin
                    if (hi > lo) begin
                        cov_next = cov_reg + (hi - lo);
                    end
                end
            endcase
        end else if (cmd.wpend) begin
            wr_req = 1'b1;
            wr_a   = pend_a_reg;
            wr_z   = pend_z_reg;
        end else if (cmd.fin && op_reg == OP_MARK) begin
            if (phase_reg == PH_BEFORE) begin
                wr_req = 1'b1;
                wr_a   = s_reg;
                wr_z   = e_reg;
            end else if (phase_reg == PH_MERGE) begin
                wr_req = 1'b1;
                wr_a   = acc_s_reg;
                wr_z   = acc_e_reg;
            end
        end
    end

    always_comb begin
        stat.req_ok   = req_ok;
        stat.is_query = (op_reg == OP_QUERY);
        stat.more     = (i_reg < n_reg);
        stat.pend_req = pend_set;
        stat.div_last = (div_cnt_reg == DIV_CNT_W'(FRAC_BITS - 1));
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    // interval memory: two banks, read from the live one, rewrite into the other
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[{bank_reg, i_reg[AW-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_req && w_reg < MAX_CNT) begin
            mem[{~bank_reg, w_reg[AW-1:0]}] <= {wr_z, wr_a};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= operation;
            s_reg  <= s_in;
            e_reg  <= e_in;
        end
        if (cmd.proc) begin
            phase_reg <= phase_next;
            acc_s_reg <= acc_s_next;
            acc_e_reg <= acc_e_next;
            cov_reg   <= cov_next;
            if (pend_set) begin
                pend_a_reg <= (op_reg == OP_CLEAR) ? e_reg : ent_a;
                pend_z_reg <= ent_z;
            end
        end
        if (cmd.load) begin
            phase_reg <= PH_BEFORE;
            cov_reg   <= '0;
        end
        if (cmd.fin) begin
            rem_reg       <= cov_reg;
            q_reg         <= '0;
            full_frac_reg <= (cov_reg >= len);
            div_cnt_reg   <= '0;
        end
        if (cmd.div) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (rem_sh >= {1'b0, len}) begin
                rem_reg <= TW'(rem_sh - {1'b0, len});
                q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[TW-1:0];
                q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.out) begin
            if (!req_ok) begin
                status_reg <= ST_IGNORED;
            end else if (op_reg != OP_QUERY && over_full) begin
                status_reg <= ST_FULL;
            end else begin
                status_reg <= ST_DONE;
            end
            if (req_ok && op_reg == OP_QUERY) begin
                frac_reg <= full_frac_reg ? FRAC_ONE : {1'b0, q_reg};
            end else begin
                frac_reg <= '0;
            end
            count_reg <= commit_ok ? COUNT_W'(w_reg) : COUNT_W'(n_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= '0;
            bank_reg     <= 1'b0;
            i_reg        <= '0;
            w_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                i_reg <= '0;
                w_reg <= '0;
            end else begin
                if (cmd.rd) begin
                    i_reg <= i_reg + 1'b1;
                end
                if (wr_req) begin
                    w_reg <= w_reg + 1'b1;
                end
            end
            if (cmd.out && commit_ok) begin
                n_reg    <= w_reg;
                bank_reg <= ~bank_reg;
            end
            if (cmd.out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign status           = status_reg;
    assign covered_fraction = frac_reg;
    assign entry_count      = count_reg;

    a_write_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, w_reg} <= {1'b0, i_reg} + 1'b1)
        else $error("rewrite pointer ran ahead of read pointer");

    a_cover_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin && op_reg == OP_QUERY && req_ok |-> cov_reg <= len)
        else $error("covered time exceeds region length");

    a_div_query_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div |-> op_reg == OP_QUERY && req_ok)
        else $error("division step outside a query");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_CNT)
        else $error("stored count above table size");

endmodule

// ===== design/interval_set_table.sv =====
// interval_set_table: one request at a time, accepted only while the sequencer is idle
// each entry takes a memory read state and a process state; an ignored request goes from read straight to output
// an insertion or a split adds a pending-write state, a query adds one divider step per fraction bit
// reset clears the interval count and the result channel, memory contents stay undefined
// depends on ist_pkg, ist_ctrl, ist_dp
module interval_set_table #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], range_start[33:2], range_end[65:34], zero fill
    input  logic [ist_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], covered_fraction[18:2], entry_count[25:19], zero fill
    output logic [ist_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ist_pkg::*;

    ist_cmd_t            cmd;
    ist_stat_t           stat;
    logic [STATUS_W-1:0] status;
    logic [FRAC_W-1:0]   covered_fraction;
    logic [COUNT_W-1:0]  entry_count;

    ist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ist_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .operation        (s_tdata[1:0]),
        .range_start      (s_tdata[33:2]),
        .range_end        (s_tdata[65:34]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .status           (status),
        .covered_fraction (covered_fraction),
        .entry_count      (entry_count)
    );

    assign m_tdata = {6'b0, entry_count, covered_fraction, status};

endmodule

// ===== tb/sv/interval_set_table_checker.sv =====
// interval_set_table_checker: watches both stream channels of the interval set table,
// keeps its own sorted interval table to predict each result word and compares them
// depends on ist_pkg
module interval_set_table_checker #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ist_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ist_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            error_count,
    output int                            pending_count,
    output int                            full_seen,
    output int                            query_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import ist_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [FRAC_W-1:0]   frac;
        logic [STATUS_W-1:0] status;
    } table_result_t;

    logic [31:0] iv_lo [MAX_INTERVALS+1];
    logic [31:0] iv_hi [MAX_INTERVALS+1];
    int iv_n;
    table_result_t expected_words[$];

    function automatic logic [1:0] mark_range(logic [31:0] s, logic [31:0] e);
        int lo, hi, gone;
        logic [31:0] ns, ne;
        lo = 0;
        while (lo < iv_n && iv_hi[lo] < s) lo++;
        hi = lo;
        while (hi < iv_n && iv_lo[hi] <= e) hi++;
        if (hi == lo) begin
            if (iv_n >= MAX_INTERVALS) return ST_FULL;
            for (int i = iv_n; i > lo; i--) begin
                iv_lo[i] = iv_lo[i-1];
                iv_hi[i] = iv_hi[i-1];
            end
            iv_lo[lo] = s;
            iv_hi[lo] = e;
            iv_n++;
            return ST_DONE;
        end
        ns = iv_lo[lo] < s ? iv_lo[lo] : s;
        ne = iv_hi[hi-1] > e ? iv_hi[hi-1] : e;
        gone = hi - lo - 1;
        iv_lo[lo] = ns;
        iv_hi[lo] = ne;
        for (int i = lo + 1; i + gone < iv_n; i++) begin
            iv_lo[i] = iv_lo[i+gone];
            iv_hi[i] = iv_hi[i+gone];
        end
        iv_n -= gone;
        return ST_DONE;
    endfunction

    function automatic logic [1:0] clear_range(logic [31:0] s, logic [31:0] e);
        int w;
        logic [31:0] a, z;
        for (int i = 0; i < iv_n; i++) begin
            if (iv_lo[i] < s && e < iv_hi[i]) begin
                if (iv_n >= MAX_INTERVALS) return ST_FULL;
                for (int k = iv_n; k > i + 1; k--) begin
                    iv_lo[k] = iv_lo[k-1];
                    iv_hi[k] = iv_hi[k-1];
                end
                iv_lo[i+1] = e;
                iv_hi[i+1] = iv_hi[i];
                iv_hi[i] = s;
                iv_n++;
                return ST_DONE;
            end
        end
        w = 0;
        for (int i = 0; i < iv_n; i++) begin
            a = iv_lo[i];
            z = iv_hi[i];
            if (!(s <= a && z <= e)) begin
                if (a < s && s < z) z = s;
                if (a < e && e < z) a = e;
                iv_lo[w] = a;
                iv_hi[w] = z;
                w++;
            end
        end
        iv_n = w;
        return ST_DONE;
    endfunction

    function automatic logic [FRAC_W-1:0] covered_share(logic [31:0] s, logic [31:0] e);
        logic [63:0] len, covered, rem, q, lo, hi;
        len = 64'(e) - 64'(s);
        covered = 0;
        for (int i = 0; i < iv_n; i++) begin
            lo = iv_lo[i] > s ? iv_lo[i] : s;
            hi = iv_hi[i] < e ? iv_hi[i] : e;
            if (hi > lo) covered += hi - lo;
        end
        if (covered >= len) return FRAC_ONE;
        rem = covered;
        q = 0;
        for (int b = 0; b < FRAC_BITS; b++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= len) begin
                rem -= len;
                q |= 1;
            end
        end
        return q[FRAC_W-1:0];
    endfunction

    function automatic table_result_t apply_request(logic [1:0] op, logic [31:0] s,
                                                    logic [31:0] e);
        table_result_t r;
        r.status = ST_IGNORED;
        r.frac = '0;
        if (op != OP_NONE && s < e) begin
            if (op == OP_MARK) r.status = mark_range(s, e);
            else if (op == OP_CLEAR) r.status = clear_range(s, e);
            else begin
                r.frac = covered_share(s, e);
                r.status = ST_DONE;
            end
        end
        r.count = COUNT_W'(iv_n);
        return r;
    endfunction

    always @(posedge aclk) begin
        table_result_t exp_w, got;
        int errs;
        errs = 0;
        if (!aresetn) begin
            iv_n = 0;
            error_count <= 0;
            pending_count <= 0;
            full_seen <= 0;
            query_seen <= 0;
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (expected_words.size() == 0) begin
                    $error("result word with no request pending: %h", m_tdata);
                    errs++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got.status != exp_w.status) begin
                        $error("status expected %0d got %0d", exp_w.status, got.status);
                        errs++;
                    end
                    if (got.frac != exp_w.frac) begin
                        $error("covered_fraction expected %0d got %0d", exp_w.frac, got.frac);
                        errs++;
                    end
                    if (got.count != exp_w.count) begin
                        $error("entry_count expected %0d got %0d", exp_w.count, got.count);
                        errs++;
                    end
                    if (exp_w.status == ST_FULL) full_seen <= full_seen + 1;
                    if (exp_w.frac != 0) query_seen <= query_seen + 1;
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(apply_request(s_tdata[1:0], s_tdata[33:2],
                                                       s_tdata[65:34]));
            error_count <= error_count + errs;
            pending_count <= expected_words.size();
        end
    end
endmodule

// ===== tb/sv/interval_set_table_test.sv =====
// interval_set_table_test: clock, reset and request stimulus for the interval set table,
// with random gaps and back pressure; verdict from the checker's error count
// depends on ist_pkg, interval_set_table, interval_set_table_checker
module interval_set_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ist_pkg::*;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [M_TDATA_W-1:0] m_tdata;
    int error_count, pending_count, full_seen, query_seen;
    int cycle_count;
    bit long_hold;
    int sent;

    interval_set_table dut (.*);
    interval_set_table_checker chk (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    endfunction

    // receiver: random stalls, one long hold when asked
    initial begin
        int gap;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (2000) @(negedge aclk);
                long_hold = 0;
            end
            if ($urandom_range(0, 2) == 0) gap = 0; else gap = pick_gap();
            if (gap == 0) m_tready <= 1;
            else begin
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
                m_tready <= 1;
            end
        end
    end

    task automatic send_word(logic [1:0] op, logic [31:0] s, logic [31:0] e);
        s_tvalid = 1;
        s_tdata = {6'b0, e, s, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
        sent++;
    endtask

    task automatic send_gapped(logic [1:0] op, logic [31:0] s, logic [31:0] e);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
        repeat (gap) @(negedge aclk);
        send_word(op, s, e);
    endtask

    function automatic logic [31:0] rand_time(int span);
        return $urandom_range(0, span);
    endfunction

    task automatic random_phase(int count, int span, int mark_weight);
        logic [1:0] op;
        logic [31:0] s, e;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < mark_weight) op = OP_MARK;
            else if (r < 70) op = OP_CLEAR;
            else if (r < 97) op = OP_QUERY;
            else op = OP_NONE;
            if ($urandom_range(0, 19) == 0) begin
                s = $urandom;
                e = $urandom;
            end else begin
                s = rand_time(span);
                e = s + $urandom_range(0, span / 8 + 1);
                if ($urandom_range(0, 29) == 0) e = s;
            end
            send_gapped(op, s, e);
        end
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        long_hold = 0;
        sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        // directed: extremes, touching merges, splits, empty and reversed ranges
        send_word(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_word(OP_MARK, 32'd100, 32'd200);
        send_word(OP_MARK, 32'd200, 32'd300);
        send_word(OP_MARK, 32'd50, 32'd100);
        send_word(OP_MARK, 32'd500, 32'd600);
        send_word(OP_QUERY, 32'd120, 32'd130);
        send_word(OP_QUERY, 32'd0, 32'd1000);
        send_word(OP_QUERY, 32'd250, 32'd550);
        send_word(OP_CLEAR, 32'd150, 32'd160);
        send_word(OP_CLEAR, 32'd40, 32'd120);
        send_word(OP_CLEAR, 32'd280, 32'd520);
        send_word(OP_CLEAR, 32'd0, 32'd1000);
        send_word(OP_MARK, 32'd7, 32'd7);
        send_word(OP_MARK, 32'd9, 32'd3);
        send_word(OP_CLEAR, 32'd9, 32'd3);
        send_word(OP_QUERY, 32'd5, 32'd5);
        send_word(OP_NONE, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_NONE, 32'd1, 32'd2);
        send_word(OP_MARK, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(OP_QUERY, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 32'h0, 32'hFFFF_FFFF);
        // fill the table past its capacity with disjoint marks
        for (int i = 0; i < 66; i++) send_word(OP_MARK, 32'(i * 10), 32'(i * 10 + 5));
        send_word(OP_CLEAR, 32'd1, 32'd2);
        send_word(OP_QUERY, 32'd0, 32'd700);
        // long receiver hold while requests keep coming
        long_hold = 1;
        random_phase(40, 800, 40);
        // pause until the table has answered everything
        while (pending_count != 0) @(negedge aclk);
        random_phase(500, 4000, 45);
        random_phase(400, 200000, 35);
        random_phase(300, 1500, 60);
        random_phase(300, 60000, 25);
        random_phase(100, 32'h7FFF_FFFF, 40);
        while (pending_count != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        $display("sent %0d requests, %0d table-full results, %0d nonzero coverage queries",
                 sent, full_seen, query_seen);
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== interval_set_table.f =====
design/ist_pkg.sv
design/ist_ctrl.sv
design/ist_dp.sv
design/interval_set_table.sv
tb/sv/interval_set_table_checker.sv
tb/sv/interval_set_table_test.sv
